/* hdl/ctcgd_pkg.sv */
`default_nettype none
package ctcgd_pkg;
	localparam int MAX_STEPS = 64;
	localparam int NUM_CLASSES = 37;
	localparam int EXP_TABLE_DEPTH = 256;
	localparam int STORE_DEPTH = 64;
	localparam int STORE_CAP = (MAX_STEPS < STORE_DEPTH) ? MAX_STEPS : STORE_DEPTH;
	localparam int ALPHA_LEN = 37;
	localparam logic [15:0] LIMIT_RESET = 16'd58982;
	localparam logic [23:0] SUM_MAX = 24'hFFFFFF;
	localparam logic [22:0] TOTAL_MAX = 23'h7FFFFF;
	localparam logic [6:0] CHAR_UNKNOWN = 7'h3F;
	localparam logic [0:0] REG_LIMIT = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE, ST_EXP, ST_MUL, ST_DIV, ST_KEEP, ST_CMP, ST_EMIT, ST_REJECT
	} state_t;

	// exponential table, built at elaboration
	function automatic logic [16:0] exp_entry(input int unsigned i);
		logic [63:0] v;
		v = 64'd1 << 30;
		for (int unsigned k = 0; k < i; k++) v = (v * 64'd1008687095 + (64'd1 << 29)) >> 30;
		return 17'((v + (64'd1 << 13)) >> 14);
	endfunction

	function automatic logic [16:0] exp_of(input logic [16:0] d);
		logic [12:0] idx;
		logic [16:0] r;
		idx = d[16:4];
		r = '0;
		for (int unsigned k = 0; k < EXP_TABLE_DEPTH; k++)
			if (idx == 13'(k)) r = exp_entry(k);
		return r;
	endfunction

	function automatic logic [6:0] char_of(input logic [5:0] c);
		localparam string ALPHA = "##0123456789ABCDEFGHIJKLMNPQRSTUVWXYZ";
		logic [6:0] r;
		r = CHAR_UNKNOWN;
		for (int k = 0; k < ALPHA_LEN; k++)
			if (c == 6'(k)) r = 7'(ALPHA[k]);
		return r;
	endfunction
endpackage
`default_nettype wire

/* hdl/ctc_greedy_decode_with_confidence_top.sv */
`default_nettype none
// channel | direction | handshake     | word
// in      | input     | valid / stall | logit, step_end, sequence_end
// out     | output    | valid / stall | char_code, accepted, last
// cfg     | input     | APB           | score_limit at address 0
// A score that ends no step passes through the table read and one multiply.
// A step end adds the serial reciprocal divider, then a state to keep the class.
// A sequence end adds a compare, then emits the kept words one at a time.
// Reset is asynchronous; output stalls hold the current word.
module ctc_greedy_decode_with_confidence_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [15:0] logit,
	input  wire logic               step_end,
	input  wire logic               sequence_end,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [6:0]              char_code,
	output logic                    accepted,
	output logic                    last,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	import ctcgd_pkg::*;

	state_t state_q, state_d;
	logic [15:0] limit_q;
	logic signed [15:0] row_max_q, x_q;
	logic [23:0] exp_sum_q;
	logic [5:0]  best_q, cnt_q, prev_q;
	logic        full_q, rise_q, stend_q, send_q;
	logic [22:0] total_q;
	logic [6:0]  kept_q, k_q;
	logic [16:0] e_q;
	logic [6:0]  store [STORE_DEPTH];
	logic        dv_start, dv_done;
	logic [15:0] dv_quot;
	logic [40:0] prod;
	logic [23:0] scaled;
	logic [22:0] pass_bar;
	logic [23:0] tsum;

	ctcgd_divider u_div (.clk, .arst_n, .start(dv_start), .den(exp_sum_q),
		.done(dv_done), .quot(dv_quot));

	assign pready = 1'b1;
	assign prdata = {16'd0, (paddr[2] == REG_LIMIT) ? limit_q : 16'd0};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) limit_q <= LIMIT_RESET;
		else if (psel && penable && pwrite && paddr[2] == REG_LIMIT) limit_q <= pwdata[15:0];
	end

	assign in_stall = (state_q != ST_IDLE);
	assign prod = exp_sum_q * e_q;
	assign scaled = (prod[40:16] + 25'(prod[15])) > 25'(SUM_MAX - 24'd65536) ? SUM_MAX
		: 24'((prod[40:16] + 25'(prod[15])) + 25'd65536);
	assign tsum = {1'b0, total_q} + {8'd0, dv_quot};
	assign pass_bar = 23'(limit_q) ;

	// next state
	always_comb begin
		state_d = state_q;
		dv_start = 1'b0;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_EXP;
			ST_EXP:    state_d = ST_MUL;
			ST_MUL:    if (stend_q) begin state_d = ST_DIV; dv_start = 1'b1; end
			           else state_d = ST_IDLE;
			ST_DIV:    if (dv_done) state_d = ST_KEEP;
			ST_KEEP:   state_d = send_q ? ST_CMP : ST_IDLE;
			ST_CMP:    state_d = ST_EMIT;
			ST_EMIT:   if (!out_stall && out_valid && last) state_d = ST_IDLE;
			ST_REJECT: if (!out_stall) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	logic        pass_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_max_q <= -16'sd32768; exp_sum_q <= '0; best_q <= '0; cnt_q <= '0;
			full_q <= 1'b0; prev_q <= '0; total_q <= '0; kept_q <= '0;
			k_q <= '0; out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					x_q <= logit; send_q <= sequence_end;
					stend_q <= step_end | sequence_end;
				end
				ST_EXP: begin
					rise_q <= x_q > row_max_q;
					e_q <= exp_of(x_q > row_max_q ? 17'(x_q - row_max_q) : 17'(row_max_q - x_q));
				end
				ST_MUL: if (!full_q) begin
					if (rise_q) begin
						exp_sum_q <= scaled; row_max_q <= x_q; best_q <= cnt_q;
					end else
						exp_sum_q <= (25'(exp_sum_q) + 25'(e_q) > 25'(SUM_MAX)) ? SUM_MAX
							: 24'(exp_sum_q + 24'(e_q));
					if (32'(cnt_q) + 1 >= NUM_CLASSES || cnt_q == 6'd63) full_q <= 1'b1;
					else cnt_q <= cnt_q + 6'd1;
				end
				ST_DIV: ;
				ST_KEEP: begin
					if (best_q != '0 && best_q != prev_q && 32'(kept_q) < STORE_CAP) begin
						store[kept_q[5:0]] <= char_of(best_q);
						kept_q <= kept_q + 7'd1;
						total_q <= tsum[23] ? TOTAL_MAX : tsum[22:0];
					end
					prev_q <= best_q;
					row_max_q <= -16'sd32768; exp_sum_q <= '0; best_q <= '0;
					cnt_q <= '0; full_q <= 1'b0;
				end
				ST_CMP: begin
					pass_q <= (31'(total_q) > 31'(pass_bar) * 31'(kept_q)) && kept_q != '0;
					k_q <= '0;
				end
				ST_EMIT: begin
					if (!out_valid) begin
						if (!pass_q) begin
							char_code <= '0; accepted <= 1'b0; last <= 1'b1;
							out_valid <= 1'b1;
						end else begin
							char_code <= store[k_q[5:0]]; accepted <= 1'b1;
							last <= (k_q + 7'd1 == kept_q); out_valid <= 1'b1;
							k_q <= k_q + 7'd1;
						end
					end else if (!out_stall) begin
						out_valid <= 1'b0;
						if (last) begin prev_q <= '0; total_q <= '0; kept_q <= '0; end
					end
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

/* hdl/ctcgd_divider.sv */
`default_nettype none
// restoring divider: 2^32 / den, one quotient bit a cycle, saturated to 16 bits
module ctcgd_divider (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [23:0] den,
	output logic             done,
	output logic [15:0]      quot
);
	import ctcgd_pkg::*;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [24:0] rem_q;
	logic [32:0] q_q;
	logic [32:0] num_q;
	logic [24:0] trial;

	assign trial = {rem_q[23:0], num_q[32]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 6'd33;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			q_q <= '0;
			num_q <= 33'h1_0000_0000;
		end else if (busy_q) begin
			num_q <= {num_q[31:0], 1'b0};
			if (trial >= {1'b0, den}) begin
				rem_q <= trial - {1'b0, den};
				q_q <= {q_q[31:0], 1'b1};
			end else begin
				rem_q <= trial;
				q_q <= {q_q[31:0], 1'b0};
			end
		end
	end

	assign done = busy_q && (cnt_q == 6'd1) ? 1'b0 : (!busy_q);
	assign quot = (den == '0) ? 16'd0 : ((q_q[32:16] != '0) ? 16'hFFFF : q_q[15:0]);
endmodule
`default_nettype wire

/* hdl/ctcgd_checker.sv */
`default_nettype none
module ctcgd_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic accepted,
	input wire logic last,
	input wire logic [6:0] char_code
);
	// no input taken while a word is offered
	a_busy: assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> in_stall)
		else $error("input open during output");
	// reject word is always final
	a_rej: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> last && char_code == 7'd0) else $error("bad reject");
	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(char_code)) else $error("word dropped");
endmodule
bind ctc_greedy_decode_with_confidence_top ctcgd_checker u_chk (.clk, .arst_n, .in_valid,
	.in_stall, .out_valid, .out_stall, .accepted, .last, .char_code);
`default_nettype wire
